FILE: rtl/core/tlpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlpm_pkg: shared types and constants for the tile layer priority mixer
// Layer code fields, lane and merge result structs, CSR indexes.
// ----------------------------------------------------------------------------
package tlpm_pkg;

   localparam int PalDepth     = 256;
   localparam int NumLayers    = 3;
   localparam int CodeWidth    = 8;
   localparam int PenWidth     = 4;
   localparam int ColourWidth  = 3;
   localparam int IndexWidth   = 8;
   localparam int NibbleWidth  = 4;
   localparam int ChanWidth    = 8;
   localparam int OrderWidth   = 2;
   localparam int CsrIdxWidth  = 2;

   localparam logic [PenWidth-1:0] ColourBaseHi = 4'd8;
   localparam logic [PenWidth-1:0] PenClear     = 4'd0;

   localparam logic [CsrIdxWidth-1:0] CSR_ORDER_FIRST  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_ORDER_SECOND = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_ORDER_THIRD  = 2'd2;

   localparam logic [OrderWidth-1:0] OrderFirstReset  = 2'd2;
   localparam logic [OrderWidth-1:0] OrderSecondReset = 2'd1;
   localparam logic [OrderWidth-1:0] OrderThirdReset  = 2'd0;

   localparam logic OP_MIX   = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef enum logic [OrderWidth-1:0] {
      LAYER_A = 2'd0,
      LAYER_B = 2'd1,
      LAYER_C = 2'd2
   } layer_type;

   typedef logic [CodeWidth-1:0]  code_type;
   typedef logic [OrderWidth-1:0] order_type;
   typedef logic [IndexWidth-1:0] pal_index_type;

   typedef struct packed {
      logic          hit_lo;
      logic          hit_hi;
      pal_index_type pal_index;
   } lane_hit_type;

   typedef struct packed {
      logic          opaque;
      pal_index_type pal_index;
   } mix_type;

   typedef struct packed {
      logic [NibbleWidth-1:0] red;
      logic [NibbleWidth-1:0] green;
      logic [NibbleWidth-1:0] blue;
   } rgb_type;

endpackage
`default_nettype wire

FILE: rtl/core/tile_layer_priority_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tile_layer_priority_mixer: three-layer tilemap pixel compositor
// Takes one item per clock while the result side is not stalled. A mix item is
// decoded by three slot lanes, merged and looked up in the palette RAM. Its
// result passes the RAM read stage and then the output register, from which
// it is transferred. While a result waits, the input side takes one more item
// into the RAM read stage and then stalls. The single palette read port sets
// the rate at one pixel per clock when the output does not stall. A palette
// write item updates the RAM at its transfer and returns nothing; a later mix
// item sees the new entry.
// ----------------------------------------------------------------------------
module tile_layer_priority_mixer #(
   parameter int PALETTE_DEPTH = tlpm_pkg::PalDepth
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire                              req_operation,
   input  wire [tlpm_pkg::CodeWidth-1:0]    req_layer_a_code,
   input  wire [tlpm_pkg::CodeWidth-1:0]    req_layer_b_code,
   input  wire [tlpm_pkg::CodeWidth-1:0]    req_layer_c_code,
   input  wire [tlpm_pkg::IndexWidth-1:0]   req_entry_index,
   input  wire [tlpm_pkg::NibbleWidth-1:0]  req_entry_red,
   input  wire [tlpm_pkg::NibbleWidth-1:0]  req_entry_green,
   input  wire [tlpm_pkg::NibbleWidth-1:0]  req_entry_blue,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [tlpm_pkg::ChanWidth-1:0]   rsp_red_out,
   output logic [tlpm_pkg::ChanWidth-1:0]   rsp_green_out,
   output logic [tlpm_pkg::ChanWidth-1:0]   rsp_blue_out,
   output logic                             rsp_is_opaque,
   input  wire                              csr_write_enable,
   input  wire [tlpm_pkg::CsrIdxWidth-1:0]  csr_index,
   input  wire [tlpm_pkg::OrderWidth-1:0]   csr_wdata
);
   import tlpm_pkg::*;

   order_type     order_ff [NumLayers];
   code_type      codes [NumLayers];
   lane_hit_type  hits [NumLayers];
   mix_type       mix;
   rgb_type       wr_rgb;
   rgb_type       pal_rgb;

   logic          req_xfer;
   logic          s1_load;
   logic          s1_valid_ff;
   logic          s1_valid_in;
   logic          s1_opaque_ff;
   logic          s2_load;
   logic          s2_valid_ff;
   logic          s2_valid_in;
   logic [ChanWidth-1:0] red_ff;
   logic [ChanWidth-1:0] green_ff;
   logic [ChanWidth-1:0] blue_ff;
   logic          opaque_ff;

   // CSR
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff[0] <= OrderFirstReset;
         order_ff[1] <= OrderSecondReset;
         order_ff[2] <= OrderThirdReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ORDER_FIRST:  order_ff[0] <= csr_wdata;
            CSR_ORDER_SECOND: order_ff[1] <= csr_wdata;
            CSR_ORDER_THIRD:  order_ff[2] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign codes[0] = req_layer_a_code;
   assign codes[1] = req_layer_b_code;
   assign codes[2] = req_layer_c_code;

   for (genvar s = 0; s < NumLayers; s++) begin : g_lane
      tlpm_lane u_lane (
         .layer_sel (order_ff[s]),
         .codes     (codes),
         .hit       (hits[s])
      );
   end

   tlpm_merge u_merge (
      .hits (hits),
      .mix  (mix)
   );

   // pipeline control
   assign s2_load     = !s2_valid_ff || rsp_ready;
   assign s1_load     = !s1_valid_ff || s2_load;
   assign req_ready   = s1_load;
   assign req_xfer    = req_valid && req_ready;
   assign s1_valid_in = req_xfer && (req_operation == OP_MIX);
   assign s2_valid_in = s1_valid_ff;

   assign wr_rgb = '{red: req_entry_red, green: req_entry_green, blue: req_entry_blue};

   tlpm_palette #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (req_xfer && (req_operation == OP_WRITE)),
      .wr_addr (req_entry_index),
      .wr_data (wr_rgb),
      .rd_en   (s1_load),
      .rd_addr (mix.pal_index),
      .rd_data (pal_rgb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_opaque_ff <= mix.opaque;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_load) begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         opaque_ff <= s1_opaque_ff;
         red_ff    <= s1_opaque_ff ? {pal_rgb.red,   {NibbleWidth{1'b0}}} : '0;
         green_ff  <= s1_opaque_ff ? {pal_rgb.green, {NibbleWidth{1'b0}}} : '0;
         blue_ff   <= s1_opaque_ff ? {pal_rgb.blue,  {NibbleWidth{1'b0}}} : '0;
      end
   end

   assign rsp_valid     = s2_valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_is_opaque = opaque_ff;

endmodule
`default_nettype wire

FILE: rtl/core/tlpm_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlpm_lane: one draw slot of the mixer
// Picks the layer named by the slot's order register and decodes its code
// into an opaque flag per priority pass and a palette index.
// ----------------------------------------------------------------------------
module tlpm_lane (
   input  wire tlpm_pkg::order_type    layer_sel,
   input  wire tlpm_pkg::code_type     codes [tlpm_pkg::NumLayers],
   output tlpm_pkg::lane_hit_type      hit
);
   import tlpm_pkg::*;

   code_type               code;
   logic                   sel_ok;
   logic [PenWidth-1:0]    base;
   logic [PenWidth-1:0]    colour;
   logic [PenWidth-1:0]    pen;
   logic                   drawn;

   always_comb begin
      code   = '0;
      sel_ok = 1'b0;
      base   = ColourBaseHi;
      case (layer_sel)
         LAYER_A: begin
            code   = codes[0];
            sel_ok = 1'b1;
            base   = '0;
         end
         LAYER_B: begin
            code   = codes[1];
            sel_ok = 1'b1;
         end
         LAYER_C: begin
            code   = codes[2];
            sel_ok = 1'b1;
         end
         default: begin
            sel_ok = 1'b0;
         end
      endcase
   end

   assign pen    = code[PenWidth-1:0];
   assign colour = {1'b0, code[CodeWidth-1 -: ColourWidth]} + base;
   assign drawn  = sel_ok && (pen != PenClear);

   assign hit.hit_lo    = drawn && !code[PenWidth];
   assign hit.hit_hi    = drawn && code[PenWidth];
   assign hit.pal_index = {colour, pen};

endmodule
`default_nettype wire

FILE: rtl/core/tlpm_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlpm_merge: combines the draw slots
// Priority pass beats the normal pass; within a pass the last drawn slot wins.
// ----------------------------------------------------------------------------
module tlpm_merge (
   input  wire tlpm_pkg::lane_hit_type hits [tlpm_pkg::NumLayers],
   output tlpm_pkg::mix_type           mix
);
   import tlpm_pkg::*;

   logic          any_lo;
   logic          any_hi;
   pal_index_type idx_lo;
   pal_index_type idx_hi;

   always_comb begin
      any_lo = 1'b0;
      any_hi = 1'b0;
      idx_lo = '0;
      idx_hi = '0;
      for (int s = 0; s < NumLayers; s++) begin
         if (hits[s].hit_lo) begin
            any_lo = 1'b1;
            idx_lo = hits[s].pal_index;
         end
         if (hits[s].hit_hi) begin
            any_hi = 1'b1;
            idx_hi = hits[s].pal_index;
         end
      end
   end

   assign mix.opaque    = any_lo || any_hi;
   assign mix.pal_index = any_hi ? idx_hi : idx_lo;

endmodule
`default_nettype wire

FILE: rtl/core/tlpm_palette.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlpm_palette: palette RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tlpm_palette #(
   parameter int PALETTE_DEPTH = tlpm_pkg::PalDepth
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire tlpm_pkg::pal_index_type wr_addr,
   input  wire tlpm_pkg::rgb_type       wr_data,
   input  wire                          rd_en,
   input  wire tlpm_pkg::pal_index_type rd_addr,
   output tlpm_pkg::rgb_type            rd_data
);
   import tlpm_pkg::*;

   localparam int AddrWidth = $clog2(PALETTE_DEPTH);

   rgb_type mem [PALETTE_DEPTH];
   rgb_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[AddrWidth-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr[AddrWidth-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/tlpm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlpm_checker: port-level checks for the mixer
// Bound to the top level; watches the result channel.
// ----------------------------------------------------------------------------
module tlpm_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              rsp_valid,
   input wire                              rsp_ready,
   input wire [tlpm_pkg::ChanWidth-1:0]    rsp_red_out,
   input wire [tlpm_pkg::ChanWidth-1:0]    rsp_green_out,
   input wire [tlpm_pkg::ChanWidth-1:0]    rsp_blue_out,
   input wire                              rsp_is_opaque
);
   import tlpm_pkg::*;

   // result held until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_out)
         && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_is_opaque))
      else $error("rsp changed while stalled");

   // background pixel is black
   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_opaque |-> rsp_red_out == '0 && rsp_green_out == '0
         && rsp_blue_out == '0)
      else $error("transparent pixel not black");

   // channels carry a nibble in the upper half
   a_low_nibble: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_red_out[NibbleWidth-1:0] == '0
         && rsp_green_out[NibbleWidth-1:0] == '0 && rsp_blue_out[NibbleWidth-1:0] == '0)
      else $error("low nibble of color set");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result after reset");

endmodule

bind tile_layer_priority_mixer tlpm_checker u_tlpm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out),
   .rsp_is_opaque (rsp_is_opaque)
);
`default_nettype wire
